/* sv/sds_pkg.sv */
// shared types, constants and a helper function for the streamline direction selector
package sds_pkg;

  localparam int CompW       = 16;
  localparam int DotW        = 16;
  localparam int CfgW        = 15;
  localparam int FracBits    = 14;
  localparam int ProdW       = 2 * CompW;
  localparam int SumW        = ProdW + 2;
  localparam int RndW        = SumW + 1 - FracBits;

  localparam logic [CfgW-1:0] CosLimitRst = CfgW'(10531);
  localparam logic [SumW-1:0] RoundHalf   = SumW'(1) << (FracBits - 1);

  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } sds_vec_t;

  // per-candidate result of the dot product unit
  typedef struct packed {
    sds_vec_t          vec;
    logic [DotW-1:0]   mag;
    logic              nonzero;
  } sds_dot_t;

  // one result of a tracking step
  typedef struct packed {
    sds_vec_t          vec;
    logic [DotW-1:0]   dot;
    logic              found;
    logic              go;
  } sds_res_t;

  function automatic logic signed [CompW-1:0] neg_sat(logic signed [CompW-1:0] v);
    logic signed [CompW-1:0] r;
    if (v == {1'b1, {(CompW-1){1'b0}}}) begin
      r = {1'b0, {(CompW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

/* sv/sds_in_if.sv */
// candidate request channel: current direction, candidate direction, last flag
interface sds_in_if;
  import sds_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] cur_dir_x;
  logic signed [CompW-1:0] cur_dir_y;
  logic signed [CompW-1:0] cur_dir_z;
  logic signed [CompW-1:0] cand_x;
  logic signed [CompW-1:0] cand_y;
  logic signed [CompW-1:0] cand_z;
  logic                    last_candidate;

  modport source (
    output valid, cur_dir_x, cur_dir_y, cur_dir_z, cand_x, cand_y, cand_z, last_candidate,
    input  ready
  );

  modport sink (
    input  valid, cur_dir_x, cur_dir_y, cur_dir_z, cand_x, cand_y, cand_z, last_candidate,
    output ready
  );
endinterface

/* sv/sds_out_if.sv */
// result request channel: chosen direction, dot product and step flags
interface sds_out_if;
  import sds_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] best_x;
  logic signed [CompW-1:0] best_y;
  logic signed [CompW-1:0] best_z;
  logic [DotW-1:0]         best_dot;
  logic                    found_any;
  logic                    keep_going;

  modport source (
    output valid, best_x, best_y, best_z, best_dot, found_any, keep_going,
    input  ready
  );

  modport sink (
    input  valid, best_x, best_y, best_z, best_dot, found_any, keep_going,
    output ready
  );
endinterface

/* sv/sds_dot.sv */
// dot product unit: exact sum of products, rounded magnitude and sign alignment
module sds_dot (
  input  sds_pkg::sds_vec_t cur_i,
  input  sds_pkg::sds_vec_t cand_i,
  output sds_pkg::sds_dot_t dot_o
);
  import sds_pkg::*;

  logic signed [ProdW-1:0] prod_x, prod_y, prod_z;
  logic signed [SumW-1:0]  sum;
  logic                    neg;
  logic [SumW-1:0]         mag;
  logic [SumW:0]           rnd_sum;
  logic [RndW-1:0]         rnd;

  assign prod_x = cand_i.x * cur_i.x;
  assign prod_y = cand_i.y * cur_i.y;
  assign prod_z = cand_i.z * cur_i.z;
  assign sum    = SumW'(prod_x) + SumW'(prod_y) + SumW'(prod_z);
  assign neg    = sum[SumW-1];
  assign mag    = neg ? SumW'(-sum) : SumW'(sum);

  // round half up to q2.14, then saturate to the result width
  assign rnd_sum = {1'b0, mag} + {1'b0, RoundHalf};
  assign rnd     = rnd_sum[SumW:FracBits];

  always_comb begin
    dot_o.mag     = (|rnd[RndW-1:DotW]) ? {DotW{1'b1}} : rnd[DotW-1:0];
    dot_o.nonzero = (|cand_i.x) | (|cand_i.y) | (|cand_i.z);
    dot_o.vec     = cand_i;
    if (neg) begin
      dot_o.vec.x = neg_sat(cand_i.x);
      dot_o.vec.y = neg_sat(cand_i.y);
      dot_o.vec.z = neg_sat(cand_i.z);
    end
  end
endmodule

/* sv/sds_best.sv */
// best candidate tracker: running maximum, kept vector and step result
module sds_best (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  logic                     last_i,
  input  sds_pkg::sds_vec_t        cur_i,
  input  sds_pkg::sds_dot_t        dot_i,
  input  logic [sds_pkg::CfgW-1:0] cos_limit_i,
  output sds_pkg::sds_res_t        res_o
);
  import sds_pkg::*;

  logic [DotW-1:0] max_dot_q, max_dot_d;
  sds_vec_t        best_vec_q, best_vec_d;
  logic            found_q, found_d;
  logic            upd;
  logic            out_nonzero;

  assign upd = dot_i.nonzero && (dot_i.mag > max_dot_q);

  always_comb begin
    max_dot_d  = max_dot_q;
    best_vec_d = best_vec_q;
    found_d    = found_q;
    if (upd) begin
      max_dot_d  = dot_i.mag;
      best_vec_d = dot_i.vec;
      found_d    = 1'b1;
    end
  end

  // nothing kept: hand back the current direction
  always_comb begin
    res_o.vec   = found_d ? best_vec_d : cur_i;
    res_o.dot   = max_dot_d;
    res_o.found = found_d;
    out_nonzero = (|res_o.vec.x) | (|res_o.vec.y) | (|res_o.vec.z);
    res_o.go    = out_nonzero && (max_dot_d >= DotW'(cos_limit_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dot_q  <= '0;
      best_vec_q <= '0;
      found_q    <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        max_dot_q  <= '0;
        best_vec_q <= '0;
        found_q    <= 1'b0;
      end else begin
        max_dot_q  <= max_dot_d;
        best_vec_q <= best_vec_d;
        found_q    <= found_d;
      end
    end
  end

  a_found_matches_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q == (max_dot_q != '0))
    else $error("found flag out of step with running maximum");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_i |=> (max_dot_q == '0) && !found_q && (best_vec_q == '0))
    else $error("step state not cleared after last candidate");

  a_max_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !last_i |=> max_dot_q >= $past(max_dot_q))
    else $error("running maximum decreased within a step");
endmodule

/* sv/streamline_direction_select.sv */
// top level of the streamline direction selector
// usage:
//   cand_i carries one candidate request per cycle while ready is high: the current
//   direction, a candidate direction (q2.14) and a last flag closing the tracking step
//   result_o carries one result request per step, issued for the last
//   candidate: best vector, best |dot|, found flag and continue flag
//   cfg_we_i / cfg_data_i write the turn-angle cosine limit (q2.14)
// timing:
//   the accept edge loads the input register; for a last candidate, the dot
//   product, compare and select are then loaded into the result register
//   when it is free or its result is being taken
//   throughput is one candidate per cycle unless a last candidate waits on a
//   held result; dot product and compare are combinational between the registers
// reset:
//   clears both stages and the step state; cosine limit returns to cos 50 deg
// stall:
//   a held result blocks only a last candidate waiting in the input stage;
//   other candidates keep flowing, and ready falls once that stage is stuck
module streamline_direction_select (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sds_in_if.sink                   cand_i,
  sds_out_if.source                result_o,
  input  logic                     cfg_we_i,
  input  logic [sds_pkg::CfgW-1:0] cfg_data_i
);
  import sds_pkg::*;

  // input stage
  logic     s1_valid_q;
  sds_vec_t s1_cur_q;
  sds_vec_t s1_cand_q;
  logic     s1_last_q;
  logic     s1_adv;
  logic     in_take;

  // result stage
  logic     out_valid_q;
  sds_res_t out_q;

  logic [CfgW-1:0] cos_limit_q;

  sds_dot_t dot;
  sds_res_t res;

  // a non-last candidate needs no room in the result register
  assign s1_adv       = s1_valid_q && (!s1_last_q || !out_valid_q || result_o.ready);
  assign cand_i.ready = !s1_valid_q || s1_adv;
  assign in_take      = cand_i.valid && cand_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_limit_q <= CosLimitRst;
    end else if (cfg_we_i) begin
      cos_limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cand_i.ready) begin
      s1_valid_q <= cand_i.valid;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cur_q.x  <= cand_i.cur_dir_x;
      s1_cur_q.y  <= cand_i.cur_dir_y;
      s1_cur_q.z  <= cand_i.cur_dir_z;
      s1_cand_q.x <= cand_i.cand_x;
      s1_cand_q.y <= cand_i.cand_y;
      s1_cand_q.z <= cand_i.cand_z;
      s1_last_q   <= cand_i.last_candidate;
    end
  end

  sds_dot u_dot (
    .cur_i  (s1_cur_q),
    .cand_i (s1_cand_q),
    .dot_o  (dot)
  );

  sds_best u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s1_adv),
    .last_i      (s1_last_q),
    .cur_i       (s1_cur_q),
    .dot_i       (dot),
    .cos_limit_i (cos_limit_q),
    .res_o       (res)
  );

  // result register, loaded on the last candidate of a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_q <= res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.best_x     = out_q.vec.x;
  assign result_o.best_y     = out_q.vec.y;
  assign result_o.best_z     = out_q.vec.z;
  assign result_o.best_dot   = out_q.dot;
  assign result_o.found_any  = out_q.found;
  assign result_o.keep_going = out_q.go;

  a_stalled_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_q && !result_o.ready |-> !cand_i.ready)
    else $error("input accepted while last candidate is stuck");

  a_not_found_zero_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.dot == '0)
    else $error("result without a kept candidate has nonzero dot");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");
endmodule

/* sim/tb_streamline_direction_select.sv */
// testbench for the streamline direction selector: scoreboarded random and directed steps
module tb_streamline_direction_select;
  import sds_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 120;

  // one candidate request as offered to the block
  typedef struct packed {
    sds_vec_t cur;
    sds_vec_t cand;
    logic     last;
  } cand_req_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_data_i;

  sds_in_if  cand_if ();
  sds_out_if res_if ();

  streamline_direction_select uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cand_i     (cand_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // stimulus and scoreboard storage
  cand_req_t   cand_queue[$];
  cand_req_t   offer;
  sds_res_t    expected_dirs[$];
  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  // predictor copy of the step state and the angle limit
  logic [DotW-1:0] top_dot = '0;
  sds_vec_t        top_vec = '0;
  logic            have_top = 1'b0;
  logic [CfgW-1:0] cos_limit;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [CompW-1:0] flip_comp(input logic signed [CompW-1:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  // folds one candidate into the step state, returns 1 with the step result on a last flag
  function automatic bit pick_direction(input cand_req_t req, output sds_res_t res);
    longint          acc;
    longint          mag;
    logic [DotW-1:0] rd;
    sds_vec_t        c;
    res = '0;
    c = req.cand;
    if (c != '0) begin
      acc = longint'(c.x) * longint'(req.cur.x) + longint'(c.y) * longint'(req.cur.y)
          + longint'(c.z) * longint'(req.cur.z);
      if (acc < 0) begin
        mag = -acc;
        c.x = flip_comp(c.x);
        c.y = flip_comp(c.y);
        c.z = flip_comp(c.z);
      end else begin
        mag = acc;
      end
      mag = (mag + 8192) >> FracBits;
      rd = (mag > 65535) ? 16'hffff : mag[DotW-1:0];
      // ties keep the earlier candidate
      if (rd > top_dot) begin
        top_dot  = rd;
        top_vec  = c;
        have_top = 1'b1;
      end
    end
    if (!req.last) return 1'b0;
    // nothing beat zero: the current direction comes back
    res.vec   = have_top ? top_vec : req.cur;
    res.dot   = top_dot;
    res.found = have_top;
    res.go    = (res.vec != '0) && (top_dot >= DotW'(cos_limit));
    top_dot  = '0;
    top_vec  = '0;
    have_top = 1'b0;
    return 1'b1;
  endfunction

  function automatic sds_vec_t v3(input int x, input int y, input int z);
    sds_vec_t v;
    v.x = CompW'(x);
    v.y = CompW'(y);
    v.z = CompW'(z);
    return v;
  endfunction

  function automatic void add_req(input sds_vec_t cur, input sds_vec_t cand, input logic last);
    cand_queue.push_back('{cur: cur, cand: cand, last: last});
  endfunction

  // mostly in range, with zeros, unit values, tiny values and raw 16-bit patterns
  function automatic logic signed [CompW-1:0] draw_comp();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 6) return '0;
    if (sel < 12) return ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
    if (sel < 16) return CompW'($urandom);
    if (sel < 22) return CompW'(int'($urandom_range(0, 40)) - 20);
    return CompW'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic sds_vec_t draw_vec();
    return v3(draw_comp(), draw_comp(), draw_comp());
  endfunction

  // candidates near the current direction (either sign) land around the angle limit
  function automatic sds_vec_t draw_cand(input sds_vec_t cur);
    int unsigned sel;
    int          sg;
    sel = $urandom_range(0, 99);
    sg  = ($urandom_range(0, 1) == 1) ? -1 : 1;
    if (sel < 10) return '0;
    if (sel < 45) begin
      return v3(sg * cur.x + int'($urandom_range(0, 9000)) - 4500,
                sg * cur.y + int'($urandom_range(0, 9000)) - 4500,
                sg * cur.z + int'($urandom_range(0, 9000)) - 4500);
    end
    return draw_vec();
  endfunction

  // whole tracking steps of random length, the current direction moving now and then
  function automatic void queue_steps(input int unsigned n);
    int unsigned made;
    int unsigned len;
    sds_vec_t    cur;
    made = 0;
    while (made < n) begin
      cur = ($urandom_range(0, 99) < 5) ? '0 : draw_vec();
      len = $urandom_range(1, 6);
      for (int unsigned k = 0; k < len; k++) begin
        if (k > 0 && $urandom_range(0, 99) < 15) cur = draw_vec();
        add_req(cur, draw_cand(cur), k == len - 1);
        made++;
      end
    end
  endfunction

  task automatic write_limit(input logic [CfgW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cos_limit = v;
  endtask

  // wait for every request to go in and every result to come out, then let the pipe settle
  task automatic drain();
    do @(negedge clk_i);
    while (cand_queue.size() != 0 || cand_if.valid || expected_dirs.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  // request driver with the predictor on the accept edge
  always @(posedge clk_i) begin : drive_cand
    sds_res_t res;
    bit       quiet;
    if (!rst_ni) begin
      cand_if.valid          <= 1'b0;
      cand_if.cur_dir_x      <= '0;
      cand_if.cur_dir_y      <= '0;
      cand_if.cur_dir_z      <= '0;
      cand_if.cand_x         <= '0;
      cand_if.cand_y         <= '0;
      cand_if.cand_z         <= '0;
      cand_if.last_candidate <= 1'b0;
    end else begin
      if (cand_if.valid && cand_if.ready) begin
        if (pick_direction(offer, res)) expected_dirs.push_back(res);
        sent_cnt++;
      end
      quiet = (sent_cnt >= 200 && sent_cnt < 330);
      if (!cand_if.valid || cand_if.ready) begin
        if (cand_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
          offer = cand_queue.pop_front();
          cand_if.cur_dir_x      <= offer.cur.x;
          cand_if.cur_dir_y      <= offer.cur.y;
          cand_if.cur_dir_z      <= offer.cur.z;
          cand_if.cand_x         <= offer.cand.x;
          cand_if.cand_y         <= offer.cand.y;
          cand_if.cand_z         <= offer.cand.z;
          cand_if.last_candidate <= offer.last;
          cand_if.valid          <= 1'b1;
        end else begin
          cand_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatch_cnt++;
    end
  endtask

  // result monitor, with one long hold-off to back the block up
  always @(posedge clk_i) begin : watch_result
    sds_res_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_dirs.size() == 0) begin
          $display("%0t: result with none expected, actual dot %0h", $time, res_if.best_dot);
          mismatch_cnt++;
        end else begin
          want = expected_dirs.pop_front();
          check_field("best_x", want.vec.x, res_if.best_x);
          check_field("best_y", want.vec.y, res_if.best_y);
          check_field("best_z", want.vec.z, res_if.best_z);
          check_field("best_dot", want.dot, res_if.best_dot);
          check_field("found_any", 16'(want.found), 16'(res_if.found_any));
          check_field("keep_going", 16'(want.go), 16'(res_if.keep_going));
        end
        got_cnt++;
        if (got_cnt == 80) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= (got_cnt >= 30 && got_cnt < 60) || $urandom_range(0, 99) >= 8;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [CfgW-1:0] limits[5];
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_data_i <= '0;
    cos_limit = CfgW'(10531);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed steps under the reset limit
    @(negedge clk_i);
    add_req(v3(16384, 0, 0), v3(16384, 0, 0), 1'b1);
    add_req(v3(16384, 0, 0), v3(-16384, 0, 0), 1'b1);         // negative product flips
    add_req(v3(0, 16384, 0), v3(0, 0, 0), 1'b1);              // nothing found
    add_req(v3(0, 0, 16384), v3(0, 11585, 11585), 1'b0);
    add_req(v3(0, 0, 16384), v3(0, 0, 0), 1'b1);              // zero candidate closes step
    add_req(v3(1, 0, 0), v3(1, 0, 0), 1'b1);                  // product rounds to zero
    add_req(v3(16384, 0, 0), v3(8192, 100, 0), 1'b0);
    add_req(v3(16384, 0, 0), v3(-8192, 300, 0), 1'b0);        // tie keeps the first
    add_req(v3(16384, 0, 0), v3(4096, 0, 0), 1'b1);
    add_req(v3(11585, 11585, 0), v3(16384, 0, 0), 1'b0);
    add_req(v3(11585, 11585, 0), v3(0, -16384, 0), 1'b0);
    add_req(v3(11585, 11585, 0), v3(11585, 11585, 0), 1'b1);
    add_req(v3(16384, 16384, 16384), v3(-16384, -16384, -16384), 1'b1);
    add_req(v3(16384, 0, 0), v3(-32768, -32768, 0), 1'b1);    // flip saturates
    add_req(v3(-32768, -32768, -32768), v3(-32768, -32768, -32768), 1'b1); // dot saturates
    add_req(v3(0, 0, 0), v3(100, 200, 300), 1'b1);            // zero current direction
    add_req(v3(16384, 0, 0), v3(0, 16384, 0), 1'b0);
    add_req(v3(0, 16384, 0), v3(0, 16384, 0), 1'b1);          // per-request current direction
    add_req(v3(16384, 0, 0), v3(8192, 14189, 0), 1'b1);       // below the angle limit
    add_req(v3(32767, 32767, 32767), v3(32767, -1, -32768), 1'b1);
    drain();

    limits[0] = '0;
    limits[1] = CfgW'(16384);
    limits[2] = '1;
    limits[3] = CfgW'($urandom_range(0, 16384));
    limits[4] = CfgW'(10531);
    foreach (limits[i]) begin
      write_limit(limits[i]);
      @(negedge clk_i);
      queue_steps(PhaseItems);
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sds_pkg.sv
sv/sds_in_if.sv
sv/sds_out_if.sv
sv/sds_dot.sv
sv/sds_best.sv
sv/streamline_direction_select.sv
sim/tb_streamline_direction_select.sv
